[rtl/dqe_pkg.sv]
package dqe_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CNT_W   = 6;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_POINT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_QRY,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

[rtl/dominance_query_engine_2d.sv]
// Two-dimensional dominance query engine. Holds up to MAX_POINTS points
// (signed Q8.8 y and z plus an 8-bit tag) in a table with one read and one
// write port, kept in y order. An insert walks down from the top of the table,
// moving each entry with larger y up by one slot, and answers accepted or
// full. A query walks up from the bottom, stops at the first y above bound_y,
// reports the tag of each visited point with z at or below bound_z and closes
// with a done transaction carrying the count; clear empties the table in one
// step. One request is in progress at a time and req_stall is high meanwhile.
// The table delivers one entry per cycle through one shared compare unit,
// except where a stall on the result side holds the query walk at a point to
// be reported or holds the final response; an unused request code is dropped
// without a result. Results leave through an output register, so a new
// request is taken while the last result still waits.
module dominance_query_engine_2d #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [dqe_pkg::COORD_W-1:0] point_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] point_z,
  input  logic [dqe_pkg::TAG_W-1:0]          point_tag,
  input  logic signed [dqe_pkg::COORD_W-1:0] bound_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] bound_z,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [dqe_pkg::KIND_W-1:0]         result_kind,
  output logic [dqe_pkg::TAG_W-1:0]          reported_tag,
  output logic [dqe_pkg::CNT_W-1:0]          reported_count,
  output logic                               last
);

  // Table address and point count widths
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic             res_valid;
  logic             res_ready;
  dqe_pkg::result_t res;
  dqe_pkg::result_t out_q;

  dqe_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .point_y   (point_y),
    .point_z   (point_z),
    .point_tag (point_tag),
    .bound_y   (bound_y),
    .bound_z   (bound_z),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_kind    = out_q.kind;
  assign reported_tag   = out_q.tag;
  assign reported_count = out_q.count;
  assign last           = out_q.last;

endmodule

[rtl/dqe_table.sv]
module dqe_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  dqe_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output dqe_pkg::entry_t     rd_data
);

  dqe_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/dqe_cmp.sv]
module dqe_cmp (
  input  logic signed [dqe_pkg::COORD_W-1:0] entry_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] entry_z,
  input  logic signed [dqe_pkg::COORD_W-1:0] key_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] key_z,
  output logic                               y_gt,
  output logic                               z_gt
);

  // Signed compare of one stored entry against the current key pair
  assign y_gt = $signed(entry_y) > $signed(key_y);
  assign z_gt = $signed(entry_z) > $signed(key_z);

endmodule

[rtl/dqe_ctrl.sv]
module dqe_ctrl #(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned AW         = 5,
  parameter int unsigned CW         = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [dqe_pkg::COORD_W-1:0] point_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] point_z,
  input  logic [dqe_pkg::TAG_W-1:0]          point_tag,
  input  logic signed [dqe_pkg::COORD_W-1:0] bound_y,
  input  logic signed [dqe_pkg::COORD_W-1:0] bound_z,
  output logic                               res_valid,
  input  logic                               res_ready,
  output dqe_pkg::result_t                   res
);

  dqe_pkg::state_t state, state_next;
  logic [CW-1:0] point_count, point_count_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] rep, rep_next;
  logic signed [dqe_pkg::COORD_W-1:0] key_y, key_y_next;
  logic signed [dqe_pkg::COORD_W-1:0] key_z, key_z_next;
  logic [dqe_pkg::TAG_W-1:0] new_tag, new_tag_next;
  logic [dqe_pkg::KIND_W-1:0] resp_kind, resp_kind_next;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  dqe_pkg::entry_t rd_data, wr_data;
  logic            y_gt, z_gt;
  logic [CW-1:0]   cnt_m1, p_m1, p_m2, idx_inc;

  dqe_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dqe_cmp u_cmp (
    .entry_y (rd_data.y),
    .entry_z (rd_data.z),
    .key_y   (key_y),
    .key_z   (key_z),
    .y_gt    (y_gt),
    .z_gt    (z_gt)
  );

  assign cnt_m1  = point_count - CW'(1);
  assign p_m1    = p - CW'(1);
  assign p_m2    = p - CW'(2);
  assign idx_inc = idx + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dqe_pkg::ST_IDLE;
      point_count <= '0;
    end else begin
      state       <= state_next;
      point_count <= point_count_next;
    end
  end

  always_ff @(posedge clk) begin
    p         <= p_next;
    idx       <= idx_next;
    rep       <= rep_next;
    key_y     <= key_y_next;
    key_z     <= key_z_next;
    new_tag   <= new_tag_next;
    resp_kind <= resp_kind_next;
  end

  always_comb begin
    state_next       = state;
    point_count_next = point_count;
    p_next           = p;
    idx_next         = idx;
    rep_next         = rep;
    key_y_next       = key_y;
    key_z_next       = key_z;
    new_tag_next     = new_tag;
    resp_kind_next   = resp_kind;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '{y: key_y, z: key_z, tag: new_tag};
    res_valid        = 1'b0;
    res              = '0;
    req_stall        = (state != dqe_pkg::ST_IDLE);

    unique case (state)
      dqe_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (req_type)
            dqe_pkg::REQ_INSERT: begin
              key_y_next   = point_y;
              key_z_next   = point_z;
              new_tag_next = point_tag;
              if (point_count == CW'(MAX_POINTS)) begin
                resp_kind_next = dqe_pkg::KIND_FULL;
                state_next     = dqe_pkg::ST_RESP;
              end else begin
                p_next     = point_count;
                state_next = dqe_pkg::ST_INS;
                if (point_count != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_m1[AW-1:0];
                end
              end
            end
            dqe_pkg::REQ_QUERY: begin
              key_y_next = bound_y;
              key_z_next = bound_z;
              rep_next   = '0;
              idx_next   = '0;
              if (point_count == '0) begin
                resp_kind_next = dqe_pkg::KIND_DONE;
                state_next     = dqe_pkg::ST_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = dqe_pkg::ST_QRY;
              end
            end
            dqe_pkg::REQ_CLEAR: begin
              point_count_next = '0;
              resp_kind_next   = dqe_pkg::KIND_CLEAR;
              state_next       = dqe_pkg::ST_RESP;
            end
            default: begin
              // drop the unused code
            end
          endcase
        end
      end

      dqe_pkg::ST_INS: begin
        // rd_data holds entry p-1 whenever p is non-zero
        if (p != '0 && y_gt) begin
          wr_en   = 1'b1;
          wr_addr = p[AW-1:0];
          wr_data = rd_data;
          p_next  = p_m1;
          if (p > CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = p_m2[AW-1:0];
          end
        end else begin
          wr_en            = 1'b1;
          wr_addr          = p[AW-1:0];
          point_count_next = point_count + CW'(1);
          resp_kind_next   = dqe_pkg::KIND_ACCEPT;
          state_next       = dqe_pkg::ST_RESP;
        end
      end

      dqe_pkg::ST_QRY: begin
        // rd_data holds entry idx
        if (y_gt) begin
          resp_kind_next = dqe_pkg::KIND_DONE;
          state_next     = dqe_pkg::ST_RESP;
        end else if (z_gt || res_ready) begin
          if (!z_gt) begin
            res_valid = 1'b1;
            res       = '{kind: dqe_pkg::KIND_POINT, tag: rd_data.tag,
                          count: '0, last: 1'b0};
            rep_next  = rep + CW'(1);
          end
          if (idx_inc == point_count) begin
            resp_kind_next = dqe_pkg::KIND_DONE;
            state_next     = dqe_pkg::ST_RESP;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx_inc[AW-1:0];
            idx_next = idx_inc;
          end
        end
      end

      dqe_pkg::ST_RESP: begin
        res_valid = 1'b1;
        res.kind  = resp_kind;
        res.count = (resp_kind == dqe_pkg::KIND_DONE) ? dqe_pkg::CNT_W'(rep) : '0;
        res.last  = 1'b1;
        if (res_ready) begin
          state_next = dqe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dqe_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond table size");

  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dqe_pkg::ST_QRY) |-> (rep <= idx && idx < point_count))
    else $error("query walk out of range");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == dqe_pkg::ST_IDLE) |-> (!res_valid && !wr_en))
    else $error("activity while idle");

  a_ins_addr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == dqe_pkg::ST_INS && p <= point_count))
    else $error("table write outside insert");

endmodule
